// File: design/ipl_pkg.sv
// Package for the incompatible pair list checker.
// Holds sizes, request codes and the payload and token types. No dependencies.

package ipl_pkg;

    localparam int MAX_PAIRS = 1024;
    localparam int ID_BITS   = 17;
    localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
    localparam int IDX_W     = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_LIST = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [ID_BITS-1:0] good_id;
        logic [ID_BITS-1:0] partner_id;
        logic               last_in_list;
    } in_req_t;

    typedef struct packed {
        logic list_ok;
        logic table_overflow;
    } result_t;

    // One request as it travels down the cell row.
    typedef struct packed {
        logic               valid;
        logic               kind;
        logic               last;
        logic [ID_BITS-1:0] id;
        logic [ID_BITS-1:0] partner;
        logic [CNT_W-1:0]   count;
        logic               conflict;
        logic               overflow;
    } token_t;

endpackage

// File: design/incompatible_pair_list_checker.sv
// Top level of the incompatible pair list checker: head stage, cell row, tail.
// Depends on ipl_pkg, ipl_cell and ipl_tail.

// Each stored pair lives in one cell of a row of MAX_PAIRS cells. Every
// accepted request becomes a token that moves one cell down the row per
// cycle, so the block takes one request per cycle when the result side keeps
// up; the result of a list is registered at the tail behind the last cell.
// A load request is given the next free slot number at the head and writes
// that cell as it passes; when all slots are taken the pair is dropped and
// the sticky overflow flag is set. A list request compares its ID against
// every live cell on its way: a cell flags a conflict when one end matches
// and the other end was marked by an earlier request of the same list, then
// marks the matching end. The request that closes a list clears the marks of
// each cell it passes and produces one result at the tail. When a result
// waits unread and another one reaches the tail, the whole row holds and
// s_ready drops. No clearing pass is needed after reset.

module incompatible_pair_list_checker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ipl_pkg::in_req_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ipl_pkg::result_t m_data
);

    ipl_pkg::token_t           tok [0:ipl_pkg::MAX_PAIRS];
    ipl_pkg::token_t           head_reg;
    ipl_pkg::token_t           head_next;
    logic [ipl_pkg::CNT_W-1:0] pair_count_reg;
    logic [ipl_pkg::CNT_W-1:0] pair_count_next;
    logic                      overflow_reg;
    logic                      overflow_next;
    logic                      advance;
    logic                      accept;
    logic                      full;

    assign s_ready = advance;
    assign accept  = s_valid && advance;
    assign full    = pair_count_reg == ipl_pkg::CNT_W'(ipl_pkg::MAX_PAIRS);

    // Build the head token and advance the slot counter and overflow flag.
    always_comb begin
        pair_count_next = pair_count_reg;
        overflow_next   = overflow_reg;
        if (accept && (s_data.req_type == ipl_pkg::REQ_LOAD)) begin
            if (full) begin
                overflow_next = 1'b1;
            end else begin
                pair_count_next = pair_count_reg + 1'b1;
            end
        end

        head_next.valid    = accept;
        head_next.kind     = s_data.req_type;
        head_next.last     = s_data.last_in_list;
        head_next.id       = s_data.good_id;
        head_next.partner  = s_data.partner_id;
        head_next.count    = pair_count_reg;
        head_next.conflict = 1'b0;
        head_next.overflow = overflow_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_count_reg <= '0;
            overflow_reg   <= 1'b0;
            head_reg       <= '0;
        end else begin
            pair_count_reg <= pair_count_next;
            overflow_reg   <= overflow_next;
            if (advance) begin
                head_reg <= head_next;
            end
        end
    end

    assign tok[0] = head_reg;

    // Row of pair cells; each hands its token to the next.
    for (genvar g = 0; g < ipl_pkg::MAX_PAIRS; g++) begin : g_cell
        ipl_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .cell_idx (ipl_pkg::IDX_W'(g)),
            .tok_in   (tok[g]),
            .tok_out  (tok[g+1])
        );
    end

    // Collect list conflicts and drive the result register.
    ipl_tail u_tail (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tok_in  (tok[ipl_pkg::MAX_PAIRS]),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .advance (advance)
    );

endmodule

// File: design/ipl_cell.sv
// One cell of the pair row: one stored pair, its seen marks and a token stage.
// Depends on ipl_pkg.

module ipl_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic [ipl_pkg::IDX_W-1:0] cell_idx,
    input  ipl_pkg::token_t           tok_in,
    output ipl_pkg::token_t           tok_out
);

    logic [ipl_pkg::ID_BITS-1:0] pair_first_reg;
    logic [ipl_pkg::ID_BITS-1:0] pair_second_reg;
    logic [1:0]                  seen_reg;
    logic [1:0]                  seen_next;
    ipl_pkg::token_t             tok_reg;
    ipl_pkg::token_t             tok_next;
    logic                        live;
    logic                        is_list;
    logic                        wr_en;
    logic                        m_first;
    logic                        m_second;

    always_comb begin
        live     = tok_in.count > ipl_pkg::CNT_W'(cell_idx);
        is_list  = tok_in.valid && (tok_in.kind == ipl_pkg::REQ_LIST);
        wr_en    = tok_in.valid && (tok_in.kind == ipl_pkg::REQ_LOAD)
                   && (tok_in.count == ipl_pkg::CNT_W'(cell_idx));
        m_first  = is_list && live && (pair_first_reg == tok_in.id);
        m_second = is_list && live && (pair_second_reg == tok_in.id);

        // Check against marks left by earlier requests, then mark.
        tok_next          = tok_in;
        tok_next.conflict = tok_in.conflict | (m_first & seen_reg[1])
                            | (m_second & seen_reg[0]);

        seen_next = seen_reg | {m_second, m_first};
        if (wr_en || (is_list && tok_in.last)) begin
            seen_next = 2'b00;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg  <= '0;
            seen_reg <= 2'b00;
        end else if (advance) begin
            tok_reg  <= tok_next;
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && wr_en) begin
            pair_first_reg  <= tok_in.id;
            pair_second_reg <= tok_in.partner;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: design/ipl_tail.sv
// Tail of the cell row: list conflict accumulation and the result register.
// Depends on ipl_pkg.

module ipl_tail (
    input  logic             aclk,
    input  logic             aresetn,
    input  ipl_pkg::token_t  tok_in,
    input  logic             m_ready,
    output logic             m_valid,
    output ipl_pkg::result_t m_data,
    output logic             advance
);

    logic             out_valid_reg;
    logic             out_valid_next;
    ipl_pkg::result_t out_data_reg;
    ipl_pkg::result_t out_data_next;
    logic             conf_acc_reg;
    logic             conf_acc_next;
    logic             is_list;
    logic             emits;

    always_comb begin
        is_list = tok_in.valid && (tok_in.kind == ipl_pkg::REQ_LIST);
        emits   = is_list && tok_in.last;
        // Freeze the row while a result waits and another one arrives.
        advance = !(emits && out_valid_reg && !m_ready);

        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        conf_acc_next  = conf_acc_reg;
        if (advance && is_list) begin
            conf_acc_next = conf_acc_reg | tok_in.conflict;
            if (tok_in.last) begin
                out_valid_next               = 1'b1;
                out_data_next.list_ok        = !(conf_acc_reg | tok_in.conflict);
                out_data_next.table_overflow = tok_in.overflow;
                conf_acc_next                = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            conf_acc_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            conf_acc_reg  <= conf_acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
